// File: src/pid_with_integral_separation_macros.svh
// Assertion macros shared by the PID controller RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PID_WITH_INTEGRAL_SEPARATION_MACROS_SVH
`define PID_WITH_INTEGRAL_SEPARATION_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PIDIS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PIDIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pidis_pkg.sv
// Shared types and constants for the PID controller with integral separation.
// No dependencies; used by the config register file and the top level.
package pidis_pkg;

    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 30;
    localparam int THR_W      = 16;
    localparam int SUM_W      = LIMIT_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_GAIN_P    = 3'd0;
    localparam t_cfg_idx REG_GAIN_I    = 3'd1;
    localparam t_cfg_idx REG_GAIN_D    = 3'd2;
    localparam t_cfg_idx REG_DRIVE_MIN = 3'd3;
    localparam t_cfg_idx REG_DRIVE_MAX = 3'd4;
    localparam t_cfg_idx REG_INT_LIMIT = 3'd5;
    localparam t_cfg_idx REG_SEP_THR   = 3'd6;

    localparam logic [GAIN_W-1:0]  DRIVE_MIN_RST = 16'h8000;
    localparam logic [GAIN_W-1:0]  DRIVE_MAX_RST = 16'h7FFF;
    localparam logic [LIMIT_W-1:0] INT_LIMIT_RST = 30'd1000;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [GAIN_W-1:0] drive_min;
        logic signed [GAIN_W-1:0] drive_max;
        logic [LIMIT_W-1:0]       integral_limit;
        logic [THR_W-1:0]         separation_threshold;
    } t_cfg;

endpackage

// File: src/pidis_in_if.sv
// Request channel of the PID controller: valid/ready plus mode, target, measured.
// Standalone interface; no package dependency.
interface pidis_in_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] target;
    logic signed [DATA_WIDTH-1:0] measured;

    modport source (output valid, mode, target, measured, input ready);
    modport sink   (input valid, mode, target, measured, output ready);
endinterface

// File: src/pidis_out_if.sv
// Result channel of the PID controller: valid/ready plus drive and error.
// Standalone interface; no package dependency.
interface pidis_out_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                       valid;
    logic                       ready;
    logic signed [DATA_WIDTH-1:0] drive;
    logic signed [DATA_WIDTH:0]   error;

    modport source (output valid, drive, error, input ready);
    modport sink   (input valid, drive, error, output ready);
endinterface

// File: src/pidis_cfg_regs.sv
// Configuration register file for the PID controller.
// Depends on pidis_pkg for register indexes, reset values and t_cfg.
module pidis_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  pidis_pkg::t_cfg_idx                 i_index,
    input  logic [pidis_pkg::CFG_DATA_W-1:0]    i_data,
    output pidis_pkg::t_cfg                     o_cfg
);

    pidis_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p               <= '0;
            r_cfg.gain_i               <= '0;
            r_cfg.gain_d               <= '0;
            r_cfg.drive_min            <= pidis_pkg::DRIVE_MIN_RST;
            r_cfg.drive_max            <= pidis_pkg::DRIVE_MAX_RST;
            r_cfg.integral_limit       <= pidis_pkg::INT_LIMIT_RST;
            r_cfg.separation_threshold <= '0;
        end else if (i_we) begin
            unique case (i_index)
                pidis_pkg::REG_GAIN_P:    r_cfg.gain_p <= i_data[pidis_pkg::GAIN_W-1:0];
                pidis_pkg::REG_GAIN_I:    r_cfg.gain_i <= i_data[pidis_pkg::GAIN_W-1:0];
                pidis_pkg::REG_GAIN_D:    r_cfg.gain_d <= i_data[pidis_pkg::GAIN_W-1:0];
                pidis_pkg::REG_DRIVE_MIN: r_cfg.drive_min <= i_data[pidis_pkg::GAIN_W-1:0];
                pidis_pkg::REG_DRIVE_MAX: r_cfg.drive_max <= i_data[pidis_pkg::GAIN_W-1:0];
                pidis_pkg::REG_INT_LIMIT: begin
                    r_cfg.integral_limit <= i_data[pidis_pkg::LIMIT_W-1:0];
                end
                pidis_pkg::REG_SEP_THR: begin
                    r_cfg.separation_threshold <= i_data[pidis_pkg::THR_W-1:0];
                end
                default: ;  // unused index: write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/pid_with_integral_separation.sv
// Positional PID controller with integral separation, one drive per request.
// A request moves through the stage 1, stage 2, stage 3 and output registers to o_out_ch.
// Throughput: one request per cycle; input stalls only while the output skid holds a
// result, i.e. after the sink refuses a result with the next one right behind it.
// Reset (synchronous, active low): config to defaults, integrator, previous error and all
// valids cleared; no clearing pass. Uses pidis_pkg, both interfaces and pidis_cfg_regs.
`include "pid_with_integral_separation_macros.svh"

module pid_with_integral_separation #(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pidis_in_if.sink                         i_in_ch,
    pidis_out_if.source                      o_out_ch,
    input  logic                             i_cfg_we,
    input  pidis_pkg::t_cfg_idx              i_cfg_index,
    input  logic [pidis_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Datapath widths. Error is one bit wider than the data, the difference
    // two bits wider. The integrator holds +-limit, so LIMIT_W+1 bits suffice.
    localparam int EW   = DATA_WIDTH + 1;
    localparam int DFW  = DATA_WIDTH + 2;
    localparam int SW   = pidis_pkg::SUM_W;
    localparam int CW   = ((EW > SW) ? EW : SW) + 1;            // sum + error
    localparam int MW   = (EW > pidis_pkg::THR_W) ? EW : pidis_pkg::THR_W;
    localparam int PPW  = pidis_pkg::GAIN_W + EW;
    localparam int PIW  = pidis_pkg::GAIN_W + SW;
    localparam int PDW  = pidis_pkg::GAIN_W + DFW;
    localparam int AW   = ((PIW > PDW) ? PIW : PDW) + 2;        // three-term sum

    pidis_pkg::t_cfg cfg;

    pidis_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // ------------------------------------------------------------------
    // Global pipeline advance. The whole pipe moves unless the skid slot
    // behind the output register is occupied; that flag is registered, so
    // ready never depends combinationally on the sink.
    // ------------------------------------------------------------------
    logic r_skid_valid;
    logic r_out_valid;
    logic en;
    logic in_fire;

    assign en             = !r_skid_valid;
    assign i_in_ch.ready  = en;
    assign in_fire        = i_in_ch.valid && en;

    // Stage 1: request register
    logic                         r_s1_valid;
    logic                         r_s1_mode;
    logic signed [DATA_WIDTH-1:0] r_s1_target;
    logic signed [DATA_WIDTH-1:0] r_s1_measured;

    // Controller state
    logic signed [EW-1:0] r_prev_error;
    logic signed [SW-1:0] r_error_sum;

    // Stage 2: error, difference and updated integrator
    logic                  r_s2_valid;
    logic                  r_s2_clear;
    logic signed [EW-1:0]  r_s2_err;
    logic signed [DFW-1:0] r_s2_diff;
    logic signed [SW-1:0]  r_s2_sum;

    // Stage 3: the three products
    logic                  r_s3_valid;
    logic                  r_s3_clear;
    logic signed [EW-1:0]  r_s3_err;
    logic signed [PPW-1:0] r_s3_prod_p;
    logic signed [PIW-1:0] r_s3_prod_i;
    logic signed [PDW-1:0] r_s3_prod_d;

    logic s1_fire;
    assign s1_fire = en && r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= in_fire;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_mode     <= i_in_ch.mode;
            r_s1_target   <= i_in_ch.target;
            r_s1_measured <= i_in_ch.measured;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 logic: error, derivative difference, integral separation
    // and integrator clamp. The state registers close their loop here.
    // ------------------------------------------------------------------
    logic signed [EW-1:0]  n_err;
    logic signed [DFW-1:0] n_diff;
    logic signed [SW-1:0]  n_error_sum;

    always_comb begin
        logic [MW-1:0]        mag;
        logic                 in_band;
        logic signed [CW-1:0] cand;
        logic signed [CW-1:0] lim_pos;
        logic signed [CW-1:0] lim_neg;
        logic signed [CW-1:0] clamped;

        n_err  = EW'(r_s1_target) - EW'(r_s1_measured);
        n_diff = DFW'(n_err) - DFW'(r_prev_error);

        // |error| never reaches 2^DATA_WIDTH, so negation stays in range
        mag     = n_err[EW-1] ? MW'(-n_err) : MW'(n_err);
        in_band = (cfg.separation_threshold == '0)
               || (mag < MW'(cfg.separation_threshold));

        // outside the band the integrator restarts from zero
        cand    = in_band ? (CW'(r_error_sum) + CW'(n_err)) : '0;
        lim_pos = $signed({{(CW-pidis_pkg::LIMIT_W){1'b0}}, cfg.integral_limit});
        lim_neg = -lim_pos;

        if (cand > lim_pos) begin
            clamped = lim_pos;
        end else if (cand < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = cand;
        end

        if (r_s1_mode || (cfg.gain_i == '0)) begin
            n_error_sum = '0;
        end else begin
            n_error_sum = clamped[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error <= '0;
            r_error_sum  <= '0;
        end else if (s1_fire) begin
            r_prev_error <= r_s1_mode ? '0 : n_err;
            r_error_sum  <= n_error_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_clear <= r_s1_mode;
            r_s2_err   <= r_s1_mode ? '0 : n_err;
            r_s2_diff  <= r_s1_mode ? '0 : n_diff;
            r_s2_sum   <= n_error_sum;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 logic: three independent signed multiplies (gain x term).
    // ------------------------------------------------------------------
    logic signed [PPW-1:0] n_prod_p;
    logic signed [PIW-1:0] n_prod_i;
    logic signed [PDW-1:0] n_prod_d;

    assign n_prod_p = PPW'(r_s2_err)  * PPW'(cfg.gain_p);
    assign n_prod_i = PIW'(r_s2_sum)  * PIW'(cfg.gain_i);
    assign n_prod_d = PDW'(r_s2_diff) * PDW'(cfg.gain_d);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_clear  <= r_s2_clear;
            r_s3_err    <= r_s2_err;
            r_s3_prod_p <= n_prod_p;
            r_s3_prod_i <= n_prod_i;
            r_s3_prod_d <= n_prod_d;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 logic: sum, floor shift by the gain fraction, clamp to
    // drive_max then drive_min (min wins if the limits cross), then
    // saturate to the data range; a clear request gives zero drive and error.
    // ------------------------------------------------------------------
    logic signed [DATA_WIDTH-1:0] n_drive;
    logic signed [EW-1:0]         n_out_err;

    always_comb begin
        logic signed [AW-1:0] acc;
        logic signed [AW-1:0] shifted;
        logic signed [AW-1:0] dmax;
        logic signed [AW-1:0] dmin;
        logic signed [AW-1:0] wmax;
        logic signed [AW-1:0] wmin;
        logic signed [AW-1:0] val;

        acc     = AW'(r_s3_prod_p) + AW'(r_s3_prod_i) + AW'(r_s3_prod_d);
        shifted = acc >>> GAIN_FRAC_BITS;
        dmax    = AW'(cfg.drive_max);
        dmin    = AW'(cfg.drive_min);
        wmax    = $signed({{(AW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
        wmin    = -wmax - AW'(1);

        val = shifted;
        if (val > dmax) begin
            val = dmax;
        end
        if (val < dmin) begin
            val = dmin;
        end
        if (val > wmax) begin
            val = wmax;
        end
        if (val < wmin) begin
            val = wmin;
        end

        if (r_s3_clear) begin
            n_drive   = '0;
            n_out_err = '0;
        end else begin
            n_drive   = val[DATA_WIDTH-1:0];
            n_out_err = r_s3_err;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid slot.
    // ------------------------------------------------------------------
    logic                         s3_fire;
    logic                         out_take;
    logic                         n_out_load;
    logic                         n_out_from_skid;
    logic                         n_skid_load;
    logic signed [DATA_WIDTH-1:0] r_out_drive;
    logic signed [EW-1:0]         r_out_err;
    logic signed [DATA_WIDTH-1:0] r_skid_drive;
    logic signed [EW-1:0]         r_skid_err;

    assign s3_fire  = r_s3_valid && en;
    assign out_take = r_out_valid && o_out_ch.ready;

    always_comb begin
        n_out_from_skid = r_skid_valid && out_take;
        n_out_load      = s3_fire && (!r_out_valid || out_take);
        n_skid_load     = s3_fire && r_out_valid && !out_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (n_out_from_skid) begin
                r_skid_valid <= 1'b0;
            end else if (n_skid_load) begin
                r_skid_valid <= 1'b1;
            end

            if (n_out_from_skid || n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_from_skid) begin
            r_out_drive <= r_skid_drive;
            r_out_err   <= r_skid_err;
        end else if (n_out_load) begin
            r_out_drive <= n_drive;
            r_out_err   <= n_out_err;
        end
        if (n_skid_load) begin
            r_skid_drive <= n_drive;
            r_skid_err   <= n_out_err;
        end
    end

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.drive = r_out_drive;
    assign o_out_ch.error = r_out_err;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic sum_in_limit;
    assign sum_in_limit =
        (CW'(r_error_sum) <= $signed({{(CW-pidis_pkg::LIMIT_W){1'b0}}, cfg.integral_limit}))
        && (CW'(r_error_sum)
            >= -$signed({{(CW-pidis_pkg::LIMIT_W){1'b0}}, cfg.integral_limit}));

    `PIDIS_ASSERT_NEXT(a_sum_clamped, i_clk, i_rst_n, s1_fire, sum_in_limit, "integrator beyond limit")
    `PIDIS_ASSERT_NEXT(a_ki_zero_clears, i_clk, i_rst_n, s1_fire && (cfg.gain_i == '0), r_error_sum == '0, "integrator kept with zero ki")
    `PIDIS_ASSERT_NEXT(a_prev_err_tracks, i_clk, i_rst_n, s1_fire, r_prev_error == r_s2_err, "previous error out of step with pipeline")
    `PIDIS_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid holds a result while output is empty")

endmodule
